// ===== src/cst_pkg.sv =====
`default_nettype none
package cst_pkg;

   localparam int KEYWORD_CHARS_DEF = 9;
   localparam int POSITION_BITS_DEF = 16;

   // lexer modes
   typedef enum logic [3:0] {
      M_START     = 4'd0,
      M_IDENT     = 4'd1,
      M_DEC       = 4'd2,
      M_ZERO      = 4'd3,
      M_OCT       = 4'd4,
      M_HEX       = 4'd5,
      M_STR       = 4'd6,
      M_CHR_FIRST = 4'd7,
      M_CHR_ESC   = 4'd8,
      M_CHR_SKIP  = 4'd9,
      M_LINE_CMT  = 4'd10,
      M_BLOCK_CMT = 4'd11,
      M_OP        = 4'd12,
      M_DOTS2     = 4'd13,
      M_ERROR     = 4'd14
   } mode_type;

   // token kinds
   localparam logic [6:0] K_INT     = 7'd0;
   localparam logic [6:0] K_STRING  = 7'd1;
   localparam logic [6:0] K_IDENT   = 7'd2;
   localparam logic [6:0] K_PLUS    = 7'd3;
   localparam logic [6:0] K_MINUS   = 7'd4;
   localparam logic [6:0] K_STAR    = 7'd5;
   localparam logic [6:0] K_SLASH   = 7'd6;
   localparam logic [6:0] K_PERCENT = 7'd7;
   localparam logic [6:0] K_LPAR    = 7'd8;
   localparam logic [6:0] K_RPAR    = 7'd9;
   localparam logic [6:0] K_LSHIFT  = 7'd10;
   localparam logic [6:0] K_RSHIFT  = 7'd11;
   localparam logic [6:0] K_LT      = 7'd12;
   localparam logic [6:0] K_GT      = 7'd13;
   localparam logic [6:0] K_LE      = 7'd14;
   localparam logic [6:0] K_GE      = 7'd15;
   localparam logic [6:0] K_EQEQ    = 7'd16;
   localparam logic [6:0] K_NE      = 7'd17;
   localparam logic [6:0] K_AND     = 7'd18;
   localparam logic [6:0] K_HAT     = 7'd19;
   localparam logic [6:0] K_EXCL    = 7'd20;
   localparam logic [6:0] K_BAR     = 7'd21;
   localparam logic [6:0] K_ANDAND  = 7'd22;
   localparam logic [6:0] K_OROR    = 7'd23;
   localparam logic [6:0] K_EQ      = 7'd24;
   localparam logic [6:0] K_ADDEQ   = 7'd25;
   localparam logic [6:0] K_SUBEQ   = 7'd26;
   localparam logic [6:0] K_MULEQ   = 7'd27;
   localparam logic [6:0] K_DIVEQ   = 7'd28;
   localparam logic [6:0] K_MODEQ   = 7'd29;
   localparam logic [6:0] K_ANDEQ   = 7'd30;
   localparam logic [6:0] K_XOREQ   = 7'd31;
   localparam logic [6:0] K_OREQ    = 7'd32;
   localparam logic [6:0] K_SHLEQ   = 7'd33;
   localparam logic [6:0] K_SHREQ   = 7'd34;
   localparam logic [6:0] K_SEMI    = 7'd35;
   localparam logic [6:0] K_COMMA   = 7'd36;
   localparam logic [6:0] K_DOT     = 7'd37;
   localparam logic [6:0] K_ARROW   = 7'd38;
   localparam logic [6:0] K_LBRACE  = 7'd39;
   localparam logic [6:0] K_RBRACE  = 7'd40;
   localparam logic [6:0] K_COLON   = 7'd41;
   localparam logic [6:0] K_QUEST   = 7'd42;
   localparam logic [6:0] K_LBRACK  = 7'd43;
   localparam logic [6:0] K_RBRACK  = 7'd44;
   localparam logic [6:0] K_INC     = 7'd45;
   localparam logic [6:0] K_DEC     = 7'd46;
   localparam logic [6:0] K_DOTS    = 7'd47;
   localparam logic [6:0] K_HASH    = 7'd48;
   localparam logic [6:0] K_NEWLINE = 7'd49;
   localparam logic [6:0] K_TILDE   = 7'd50;
   localparam logic [6:0] K_END     = 7'd51;
   localparam logic [6:0] K_TEXT    = 7'd74;
   localparam logic [6:0] K_DISCARD = 7'd75;
   localparam logic [6:0] K_ERROR   = 7'd76;

   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_BADCHAR = 3'd1;
   localparam logic [2:0] E_EARLY   = 3'd2;
   localparam logic [2:0] E_NLSTR   = 3'd3;
   localparam logic [2:0] E_DOTS    = 3'd4;
   localparam logic [2:0] E_EMPTY   = 3'd5;

   // one result word
   typedef struct packed {
      logic [6:0]  kind;
      logic [31:0] value;
      logic [15:0] line;
      logic [15:0] column;
      logic [2:0]  error_code;
   } result_type;

   function automatic logic [7:0] unescape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h6e:   r = 8'd10;
         8'h74:   r = 8'd9;
         8'h72:   r = 8'd13;
         8'h30:   r = 8'd0;
         8'h61:   r = 8'd7;
         8'h62:   r = 8'd8;
         8'h66:   r = 8'd12;
         8'h76:   r = 8'd11;
         default: r = c;
      endcase
      return r;
   endfunction

   // extend a pending operator by one byte, zero when it does not extend
   function automatic logic [6:0] extend_op(input logic [6:0] p, input logic [7:0] c);
      logic [6:0] r;
      logic eq;
      eq = (c == 8'h3d);
      r = K_INT;
      case (p)
         K_PLUS:    r = (c == 8'h2b) ? K_INC : eq ? K_ADDEQ : K_INT;
         K_MINUS:   r = eq ? K_SUBEQ : (c == 8'h3e) ? K_ARROW : (c == 8'h2d) ? K_DEC : K_INT;
         K_STAR:    r = eq ? K_MULEQ : K_INT;
         K_SLASH:   r = eq ? K_DIVEQ : K_INT;
         K_PERCENT: r = eq ? K_MODEQ : K_INT;
         K_LT:      r = (c == 8'h3c) ? K_LSHIFT : eq ? K_LE : K_INT;
         K_GT:      r = (c == 8'h3e) ? K_RSHIFT : eq ? K_GE : K_INT;
         K_LSHIFT:  r = eq ? K_SHLEQ : K_INT;
         K_RSHIFT:  r = eq ? K_SHREQ : K_INT;
         K_EQ:      r = eq ? K_EQEQ : K_INT;
         K_EXCL:    r = eq ? K_NE : K_INT;
         K_AND:     r = (c == 8'h26) ? K_ANDAND : eq ? K_ANDEQ : K_INT;
         K_HAT:     r = eq ? K_XOREQ : K_INT;
         K_BAR:     r = (c == 8'h7c) ? K_OROR : eq ? K_OREQ : K_INT;
         default:   r = K_INT;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/cst_kw_match.sv =====
`default_nettype none
// Keyword lookup over the buffered first bytes of a name
module cst_kw_match #(
   parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF
) (
   input  wire logic [KEYWORD_CHARS-1:0][7:0] buf_chars,
   input  wire logic [15:0]                   text_len,
   output logic [6:0]                         kind
);
   import cst_pkg::*;

   // compare against a name held right-justified, last byte in the lowest bits
   function automatic logic hit(input logic [79:0] name, input int len,
                                input logic [KEYWORD_CHARS-1:0][7:0] b,
                                input logic [15:0] tl);
      logic ok;
      ok = (tl == 16'(len));
      for (int i = 0; i < 9; i++) begin
         if (i < len && i < KEYWORD_CHARS) begin
            if (b[i] != name[8*(len-1-i) +: 8]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   always_comb begin
      kind = K_IDENT;
      if (hit("return", 6, buf_chars, text_len)) kind = 7'd52;
      else if (hit("if", 2, buf_chars, text_len)) kind = 7'd53;
      else if (hit("else", 4, buf_chars, text_len)) kind = 7'd54;
      else if (hit("while", 5, buf_chars, text_len)) kind = 7'd55;
      else if (hit("break", 5, buf_chars, text_len)) kind = 7'd56;
      else if (hit("continue", 8, buf_chars, text_len)) kind = 7'd57;
      else if (hit("for", 3, buf_chars, text_len)) kind = 7'd58;
      else if (hit("int", 3, buf_chars, text_len)) kind = 7'd59;
      else if (hit("char", 4, buf_chars, text_len)) kind = 7'd60;
      else if (hit("sizeof", 6, buf_chars, text_len)) kind = 7'd61;
      else if (hit("switch", 6, buf_chars, text_len)) kind = 7'd62;
      else if (hit("default", 7, buf_chars, text_len)) kind = 7'd63;
      else if (hit("case", 4, buf_chars, text_len)) kind = 7'd64;
      else if (hit("goto", 4, buf_chars, text_len)) kind = 7'd65;
      else if (hit("struct", 6, buf_chars, text_len)) kind = 7'd66;
      else if (hit("typedef", 7, buf_chars, text_len)) kind = 7'd67;
      else if (hit("do", 2, buf_chars, text_len)) kind = 7'd68;
      else if (hit("void", 4, buf_chars, text_len)) kind = 7'd69;
      else if (hit("union", 5, buf_chars, text_len)) kind = 7'd70;
      else if (hit("enum", 4, buf_chars, text_len)) kind = 7'd71;
      else if (hit("static", 6, buf_chars, text_len)) kind = 7'd72;
      else if (hit("extern", 6, buf_chars, text_len)) kind = 7'd73;
      else if (hit("const", 5, buf_chars, text_len)) kind = K_DISCARD;
      else if (hit("_Noreturn", 9, buf_chars, text_len)) kind = K_DISCARD;
   end
endmodule
`default_nettype wire

// ===== src/c_source_tokenizer_top.sv =====
`default_nettype none
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  req_tdata = source_byte, req_tuser = end_of_input
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata = kind,value,line,column,error_code
//                                      rsp_tlast = last
// Each byte yields up to two result words, which sit in a two-entry output
// queue; a byte is taken whenever that queue will have room for both words,
// so the rate is one byte per cycle while the consumer keeps up. Synchronous
// reset puts the lexer at line 1, column 0.
// A stall on rsp holds req_tready low once the queue cannot take two words.
module c_source_tokenizer_top #(
   parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF,
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // source_byte
   input  wire logic        req_tuser,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // kind[6:0] value[38:7] line[54:39]
                                         // column[70:55] error_code[73:71]
   output logic             rsp_tlast    // last
);
   import cst_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // lexer state
   mode_type mode_ff, mode_in;
   logic [6:0] pend_ff, pend_in;
   logic [31:0] acc_ff, acc_in;
   logic [KEYWORD_CHARS-1:0][7:0] kbuf_ff, kbuf_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in;
   logic esc_ff, esc_in, star_ff, star_in;
   logic [7:0] chv_ff, chv_in;

   // output queue
   result_type q_data_ff [2], q_data_in [2];
   logic q_last_ff [2], q_last_in [2];
   logic [1:0] q_cnt_ff, q_cnt_in;

   logic accept, take;
   logic [6:0] kw_kind;
   result_type r0, r1;
   logic [1:0] nres;

   cst_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw (
      .buf_chars(kbuf_ff),
      .text_len (tlen_ff),
      .kind     (kw_kind)
   );

   assign take = rsp_tvalid && rsp_tready;
   assign req_tready = (q_cnt_ff == 2'd0) || (q_cnt_ff == 2'd1 && take);
   assign accept = req_tvalid && req_tready;

   // lexer next state and results
   always_comb begin
      logic [7:0] c;
      logic [15:0] pl, pc, nl, ncl;
      logic redo, isd, isa, wbuf;
      logic [7:0] pushc;
      logic [4:0] hv;
      logic [6:0] single, ext;
      logic push;
      c = req_tdata;
      mode_in = mode_ff; pend_in = pend_ff; acc_in = acc_ff; kbuf_in = kbuf_ff;
      tlen_in = tlen_ff; line_in = line_ff; col_in = col_ff; esc_in = esc_ff;
      star_in = star_ff; chv_in = chv_ff;
      r0 = '0; r1 = '0; nres = 2'd0;
      redo = 1'b0; push = 1'b0; pushc = c; single = K_INT; ext = K_INT;
      wbuf = 1'b0;
      pl = 16'(line_ff); pc = 16'(col_ff);
      nl = pl; ncl = pc;
      isd = (c >= 8'h30 && c <= 8'h39);
      isa = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
      hv = 5'h10;
      if (isd) hv = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) hv = 5'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) hv = 5'(c - 8'h37);

      if (req_tuser) begin
         // flush pending token, then end
         case (mode_ff)
            M_IDENT: r0 = '{kw_kind, 32'(tlen_ff), pl, pc, E_NONE};
            M_DEC, M_ZERO, M_OCT, M_HEX: r0 = '{K_INT, acc_ff, pl, pc, E_NONE};
            M_OP: r0 = '{pend_ff, 32'd0, pl, pc, E_NONE};
            M_STR, M_CHR_FIRST, M_CHR_ESC, M_CHR_SKIP, M_LINE_CMT, M_BLOCK_CMT,
            M_DOTS2: r0 = '{K_ERROR, 32'd0, pl, pc, E_EARLY};
            default: r0 = '0;
         endcase
         if (mode_ff == M_START || mode_ff == M_ERROR) begin
            r0 = '{K_END, 32'd0, pl, pc, E_NONE};
            nres = 2'd1;
         end else begin
            r1 = '{K_END, 32'd0, pl, pc, E_NONE};
            nres = 2'd2;
         end
         mode_in = M_START; pend_in = K_INT; acc_in = '0; tlen_in = '0;
         line_in = POSITION_BITS'(1); col_in = '0; esc_in = 1'b0; chv_in = '0;
         star_in = 1'b0;
      end else begin
         // advance position
         if (c == 8'h0a) begin
            if (line_ff < POS_MAX) line_in = line_ff + 1'b1;
            col_in = '0;
         end else if (col_ff < POS_MAX) begin
            col_in = col_ff + 1'b1;
         end
         nl = 16'(line_in); ncl = 16'(col_in);
         case (mode_ff)
            M_START: redo = 1'b1;
            M_IDENT: begin
               if (isa || isd) push = 1'b1;
               else begin
                  r0 = '{kw_kind, 32'(tlen_ff), pl, pc, E_NONE}; nres = 2'd1; redo = 1'b1;
               end
            end
            M_DEC: begin
               if (isd) acc_in = (acc_ff << 3) + (acc_ff << 1) + 32'(c - 8'h30);
               else begin
                  r0 = '{K_INT, acc_ff, pl, pc, E_NONE}; nres = 2'd1; redo = 1'b1;
               end
            end
            M_ZERO, M_OCT: begin
               if (mode_ff == M_ZERO && c == 8'h78) begin
                  acc_in = '0; mode_in = M_HEX;
               end else if (c >= 8'h30 && c <= 8'h37) begin
                  acc_in = (acc_ff << 3) + 32'(c - 8'h30); mode_in = M_OCT;
               end else begin
                  r0 = '{K_INT, acc_ff, pl, pc, E_NONE}; nres = 2'd1; redo = 1'b1;
               end
            end
            M_HEX: begin
               if (!hv[4]) acc_in = (acc_ff << 4) + 32'(hv[3:0]);
               else begin
                  r0 = '{K_INT, acc_ff, pl, pc, E_NONE}; nres = 2'd1; redo = 1'b1;
               end
            end
            M_STR: begin
               if (esc_ff) begin
                  esc_in = 1'b0; push = 1'b1; pushc = unescape(c);
               end else if (c == 8'h5c) esc_in = 1'b1;
               else if (c == 8'h22) begin
                  r0 = '{K_STRING, 32'(tlen_ff), nl, ncl, E_NONE}; nres = 2'd1;
                  mode_in = M_START;
               end else if (c == 8'h0a) begin
                  r0 = '{K_ERROR, 32'd0, nl, ncl, E_NLSTR}; nres = 2'd1;
                  mode_in = M_ERROR;
               end else push = 1'b1;
            end
            M_CHR_FIRST: begin
               if (c == 8'h27) begin
                  r0 = '{K_ERROR, 32'd0, nl, ncl, E_EMPTY}; nres = 2'd1;
                  mode_in = M_ERROR;
               end else if (c == 8'h5c) mode_in = M_CHR_ESC;
               else begin
                  chv_in = c; mode_in = M_CHR_SKIP;
               end
            end
            M_CHR_ESC: begin
               chv_in = unescape(c); mode_in = M_CHR_SKIP;
            end
            M_CHR_SKIP: begin
               if (c == 8'h27) begin
                  r0 = '{K_INT, {{24{chv_ff[7]}}, chv_ff}, nl, ncl, E_NONE}; nres = 2'd1;
                  mode_in = M_START;
               end
            end
            M_LINE_CMT: if (c == 8'h0a) mode_in = M_START;
            M_BLOCK_CMT: begin
               if (star_ff && c == 8'h2f) mode_in = M_START;
               star_in = (c == 8'h2a);
            end
            M_OP: begin
               ext = extend_op(pend_ff, c);
               if (pend_ff == K_SLASH && c == 8'h2a) begin
                  star_in = 1'b0; mode_in = M_BLOCK_CMT;
               end else if (pend_ff == K_SLASH && c == 8'h2f) mode_in = M_LINE_CMT;
               else if (pend_ff == K_DOT && c == 8'h2e) mode_in = M_DOTS2;
               else if (ext == K_LSHIFT || ext == K_RSHIFT) pend_in = ext;
               else if (ext != K_INT) begin
                  r0 = '{ext, 32'd0, nl, ncl, E_NONE}; nres = 2'd1; mode_in = M_START;
               end else begin
                  r0 = '{pend_ff, 32'd0, pl, pc, E_NONE}; nres = 2'd1; redo = 1'b1;
               end
            end
            M_DOTS2: begin
               nres = 2'd1; mode_in = M_START;
               if (c == 8'h2e) r0 = '{K_DOTS, 32'd0, nl, ncl, E_NONE};
               else begin
                  r0 = '{K_ERROR, 32'd0, nl, ncl, E_DOTS}; mode_in = M_ERROR;
               end
            end
            default: ;
         endcase

         // start a new token with this byte
         if (redo) begin
            mode_in = M_START;
            if (c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d) begin
            end else if (isd) begin
               acc_in = 32'(c - 8'h30);
               mode_in = (c == 8'h30) ? M_ZERO : M_DEC;
            end else if (isa) begin
               tlen_in = '0; mode_in = M_IDENT; push = 1'b1; pushc = c;
            end else begin
               case (c)
                  8'h22: begin tlen_in = '0; esc_in = 1'b0; mode_in = M_STR; end
                  8'h27: begin chv_in = '0; mode_in = M_CHR_FIRST; end
                  8'h2b: begin pend_in = K_PLUS; mode_in = M_OP; end
                  8'h2d: begin pend_in = K_MINUS; mode_in = M_OP; end
                  8'h2a: begin pend_in = K_STAR; mode_in = M_OP; end
                  8'h2f: begin pend_in = K_SLASH; mode_in = M_OP; end
                  8'h25: begin pend_in = K_PERCENT; mode_in = M_OP; end
                  8'h3c: begin pend_in = K_LT; mode_in = M_OP; end
                  8'h3e: begin pend_in = K_GT; mode_in = M_OP; end
                  8'h3d: begin pend_in = K_EQ; mode_in = M_OP; end
                  8'h21: begin pend_in = K_EXCL; mode_in = M_OP; end
                  8'h26: begin pend_in = K_AND; mode_in = M_OP; end
                  8'h5e: begin pend_in = K_HAT; mode_in = M_OP; end
                  8'h7c: begin pend_in = K_BAR; mode_in = M_OP; end
                  8'h2e: begin pend_in = K_DOT; mode_in = M_OP; end
                  8'h28: single = K_LPAR;
                  8'h29: single = K_RPAR;
                  8'h3b: single = K_SEMI;
                  8'h2c: single = K_COMMA;
                  8'h7b: single = K_LBRACE;
                  8'h7d: single = K_RBRACE;
                  8'h3a: single = K_COLON;
                  8'h3f: single = K_QUEST;
                  8'h5b: single = K_LBRACK;
                  8'h5d: single = K_RBRACK;
                  8'h23: single = K_HASH;
                  8'h0a: single = K_NEWLINE;
                  8'h7e: single = K_TILDE;
                  default: begin
                     mode_in = M_ERROR;
                     single = K_ERROR;
                  end
               endcase
            end
            if (single != K_INT) begin
               if (nres == 2'd0)
                  r0 = '{single, 32'd0, nl, ncl, (single == K_ERROR) ? E_BADCHAR : E_NONE};
               else
                  r1 = '{single, 32'd0, nl, ncl, (single == K_ERROR) ? E_BADCHAR : E_NONE};
               nres = nres + 2'd1;
            end
         end

         // text byte: buffer it and emit
         if (push) begin
            wbuf = (redo ? 16'd0 : tlen_ff) < 16'(KEYWORD_CHARS);
            if (redo) begin
               kbuf_in[0] = pushc;
               tlen_in = 16'd1;
            end else begin
               for (int i = 0; i < KEYWORD_CHARS; i++)
                  if (wbuf && tlen_ff == 16'(i)) kbuf_in[i] = pushc;
               if (tlen_ff != 16'hffff) tlen_in = tlen_ff + 16'd1;
            end
            if (nres == 2'd0) r0 = '{K_TEXT, 32'(pushc), nl, ncl, E_NONE};
            else r1 = '{K_TEXT, 32'(pushc), nl, ncl, E_NONE};
            nres = nres + 2'd1;
         end
      end
   end

   // output queue: shift out on take, append on accept
   always_comb begin
      result_type d [2];
      logic l [2];
      logic [1:0] n;
      d[0] = q_data_ff[0]; d[1] = q_data_ff[1];
      l[0] = q_last_ff[0]; l[1] = q_last_ff[1];
      n = q_cnt_ff;
      if (take) begin
         d[0] = d[1]; l[0] = l[1]; n = n - 2'd1;
      end
      if (accept) begin
         if (nres == 2'd2) begin
            d[0] = r0; l[0] = 1'b0; d[1] = r1; l[1] = 1'b1;
         end else if (nres == 2'd1) begin
            if (n == 2'd0) begin d[0] = r0; l[0] = 1'b1; end
            else begin d[1] = r0; l[1] = 1'b1; end
         end
         n = n + nres;
      end
      q_data_in[0] = d[0]; q_data_in[1] = d[1];
      q_last_in[0] = l[0]; q_last_in[1] = l[1];
      q_cnt_in = n;
   end

   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_tdata = {6'd0, q_data_ff[0].error_code, q_data_ff[0].column,
                       q_data_ff[0].line, q_data_ff[0].value, q_data_ff[0].kind};
   assign rsp_tlast = q_last_ff[0];

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_START; pend_ff <= K_INT; acc_ff <= '0; tlen_ff <= '0;
         line_ff <= POSITION_BITS'(1); col_ff <= '0; esc_ff <= 1'b0;
         star_ff <= 1'b0; chv_ff <= '0; q_cnt_ff <= 2'd0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in; pend_ff <= pend_in; acc_ff <= acc_in;
            tlen_ff <= tlen_in; line_ff <= line_in; col_ff <= col_in;
            esc_ff <= esc_in; star_ff <= star_in; chv_ff <= chv_in;
         end
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) kbuf_ff <= kbuf_in;
      q_data_ff[0] <= q_data_in[0]; q_data_ff[1] <= q_data_in[1];
      q_last_ff[0] <= q_last_in[0]; q_last_ff[1] <= q_last_in[1];
   end

`ifndef SYNTH
   a_cnt: assert property (@(posedge clock) disable iff (reset) q_cnt_ff != 2'd3)
      else $error("queue overflow");
   a_end: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> mode_ff == M_START && line_ff == POSITION_BITS'(1))
      else $error("end did not reset lexer");
   a_last: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff == 2'd2 |-> !q_last_ff[0] || q_last_ff[1])
      else $error("queue tail not last");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_c_source_tokenizer_top.sv =====
`default_nettype none
module tb_c_source_tokenizer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cst_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int KW_LEN      = 9;
   localparam int ITEM_TARGET = 1300;
   localparam logic [6:0] K_KW_FIRST = 7'd52;

   typedef struct {
      logic [6:0]  kind;
      logic [31:0] value;
      logic [15:0] line;
      logic [15:0] column;
      logic [2:0]  err;
      bit          last;
   } token_word;

   // token predictor and the queue of tokens still owed by the block
   class token_scoreboard;
      mode_type    mode;
      logic [6:0]  pend_op;
      logic [31:0] acc;
      logic [7:0]  kw_buf [KW_LEN];
      logic [15:0] text_len;
      logic [15:0] line_no;
      logic [15:0] col_no;
      bit          esc;
      logic [7:0]  chr_val;
      bit          star;
      token_word   step_q[$];
      token_word   owed_q[$];
      int          bytes_seen, ends_seen, tokens_ok, error_tokens, mismatches;
      string       kw_name [24] = '{"return", "if", "else", "while", "break", "continue",
         "for", "int", "char", "sizeof", "switch", "default", "case", "goto", "struct",
         "typedef", "do", "void", "union", "enum", "static", "extern", "const",
         "_Noreturn"};

      function void clear_lexer();
         mode = M_START; pend_op = 0; acc = 0; text_len = 0;
         line_no = 1; col_no = 0; esc = 0; chr_val = 0; star = 0;
      endfunction

      function void put(logic [6:0] k, logic [31:0] v, logic [15:0] ln,
                        logic [15:0] col, logic [2:0] e);
         token_word t;
         t.kind = k; t.value = v; t.line = ln; t.column = col; t.err = e; t.last = 0;
         if (step_q.size() < 2) step_q.push_back(t);
      endfunction

      function void raise_error(logic [2:0] e);
         put(K_ERROR, 0, line_no, col_no, e);
         mode = M_ERROR;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      function int hex_digit(logic [7:0] c);
         if (is_digit(c)) return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function logic [7:0] decode_escape(logic [7:0] c);
         case (c)
            "n": return 8'd10;
            "t": return 8'd9;
            "r": return 8'd13;
            "0": return 8'd0;
            "a": return 8'd7;
            "b": return 8'd8;
            "f": return 8'd12;
            "v": return 8'd11;
            default: return c;
         endcase
      endfunction

      function void push_text(logic [7:0] c);
         if (text_len < KW_LEN) kw_buf[text_len] = c;
         if (text_len != 16'hFFFF) text_len++;
         put(K_TEXT, {24'd0, c}, line_no, col_no, E_NONE);
      endfunction

      // classify a finished name: keyword, discarded qualifier or plain ident
      function void close_name(logic [15:0] ln, logic [15:0] col);
         logic [6:0] k;
         bit hit;
         k = K_IDENT;
         if (text_len <= KW_LEN) begin
            for (int i = 0; i < 24; i++) begin
               if (kw_name[i].len() == text_len) begin
                  hit = 1;
                  for (int j = 0; j < text_len; j++)
                     if (kw_name[i][j] != kw_buf[j]) hit = 0;
                  if (hit) begin
                     k = (i >= 22) ? K_DISCARD : K_KW_FIRST + 7'(i);
                     break;
                  end
               end
            end
         end
         put(k, {16'd0, text_len}, ln, col, E_NONE);
      endfunction

      function logic [6:0] grow_op(logic [6:0] p, logic [7:0] c);
         case (p)
            K_PLUS:    return c == "+" ? K_INC : c == "=" ? K_ADDEQ : K_INT;
            K_MINUS:   return c == "=" ? K_SUBEQ : c == ">" ? K_ARROW :
                              c == "-" ? K_DEC : K_INT;
            K_STAR:    return c == "=" ? K_MULEQ : K_INT;
            K_SLASH:   return c == "=" ? K_DIVEQ : K_INT;
            K_PERCENT: return c == "=" ? K_MODEQ : K_INT;
            K_LT:      return c == "<" ? K_LSHIFT : c == "=" ? K_LE : K_INT;
            K_GT:      return c == ">" ? K_RSHIFT : c == "=" ? K_GE : K_INT;
            K_LSHIFT:  return c == "=" ? K_SHLEQ : K_INT;
            K_RSHIFT:  return c == "=" ? K_SHREQ : K_INT;
            K_EQ:      return c == "=" ? K_EQEQ : K_INT;
            K_EXCL:    return c == "=" ? K_NE : K_INT;
            K_AND:     return c == "&" ? K_ANDAND : c == "=" ? K_ANDEQ : K_INT;
            K_HAT:     return c == "=" ? K_XOREQ : K_INT;
            K_BAR:     return c == "|" ? K_OROR : c == "=" ? K_OREQ : K_INT;
            default:   return K_INT;
         endcase
      endfunction

      // begin a new token on this byte
      function void open_token(logic [7:0] c);
         logic [6:0] single;
         single = 0;
         mode = M_START;
         if (c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13) return;
         if (is_digit(c)) begin
            acc = c - "0";
            mode = (c == "0") ? M_ZERO : M_DEC;
            return;
         end
         if (is_alpha(c)) begin
            text_len = 0; mode = M_IDENT; push_text(c);
            return;
         end
         case (c)
            "\"": begin text_len = 0; esc = 0; mode = M_STR; return; end
            "'":  begin chr_val = 0; mode = M_CHR_FIRST; return; end
            "+": pend_op = K_PLUS;
            "-": pend_op = K_MINUS;
            "*": pend_op = K_STAR;
            "/": pend_op = K_SLASH;
            "%": pend_op = K_PERCENT;
            "<": pend_op = K_LT;
            ">": pend_op = K_GT;
            "=": pend_op = K_EQ;
            "!": pend_op = K_EXCL;
            "&": pend_op = K_AND;
            "^": pend_op = K_HAT;
            "|": pend_op = K_BAR;
            ".": pend_op = K_DOT;
            "(": single = K_LPAR;
            ")": single = K_RPAR;
            ";": single = K_SEMI;
            ",": single = K_COMMA;
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            ":": single = K_COLON;
            "?": single = K_QUEST;
            "[": single = K_LBRACK;
            "]": single = K_RBRACK;
            "#": single = K_HASH;
            8'd10: single = K_NEWLINE;
            "~": single = K_TILDE;
            default: begin raise_error(E_BADCHAR); return; end
         endcase
         if (single != 0) put(single, 0, line_no, col_no, E_NONE);
         else mode = M_OP;
      endfunction

      // flush whatever is pending, then the end token, then start afresh
      function void close_source();
         case (mode)
            M_IDENT: close_name(line_no, col_no);
            M_DEC, M_ZERO, M_OCT, M_HEX: put(K_INT, acc, line_no, col_no, E_NONE);
            M_OP: put(pend_op, 0, line_no, col_no, E_NONE);
            M_STR, M_CHR_FIRST, M_CHR_ESC, M_CHR_SKIP, M_LINE_CMT, M_BLOCK_CMT, M_DOTS2: begin
               put(K_ERROR, 0, line_no, col_no, E_EARLY);
               error_tokens++;
            end
            default: ;
         endcase
         put(K_END, 0, line_no, col_no, E_NONE);
         clear_lexer();
      endfunction

      // note one accepted input word and queue the tokens it causes
      function void note_byte(logic [7:0] c, bit eoi);
         logic [15:0] ol, oc;
         logic [6:0]  ext;
         bit redo;
         int h;
         step_q.delete();
         redo = 0;
         if (eoi) begin
            ends_seen++;
            close_source();
         end else begin
            bytes_seen++;
            ol = line_no; oc = col_no;
            if (c == 8'd10) begin
               if (line_no != 16'hFFFF) line_no++;
               col_no = 0;
            end else if (col_no != 16'hFFFF) col_no++;
            case (mode)
               M_START: redo = 1;
               M_IDENT:
                  if (is_alpha(c) || is_digit(c)) push_text(c);
                  else begin close_name(ol, oc); redo = 1; end
               M_DEC:
                  if (is_digit(c)) acc = acc * 10 + (c - "0");
                  else begin put(K_INT, acc, ol, oc, E_NONE); redo = 1; end
               M_ZERO, M_OCT:
                  if (mode == M_ZERO && c == "x") begin acc = 0; mode = M_HEX; end
                  else if (c >= "0" && c <= "7") begin
                     acc = acc * 8 + (c - "0"); mode = M_OCT;
                  end else begin put(K_INT, acc, ol, oc, E_NONE); redo = 1; end
               M_HEX: begin
                  h = hex_digit(c);
                  if (h >= 0) acc = acc * 16 + h;
                  else begin put(K_INT, acc, ol, oc, E_NONE); redo = 1; end
               end
               M_STR:
                  if (esc) begin esc = 0; push_text(decode_escape(c)); end
                  else if (c == "\\") esc = 1;
                  else if (c == "\"") begin
                     put(K_STRING, {16'd0, text_len}, line_no, col_no, E_NONE);
                     mode = M_START;
                  end else if (c == 8'd10) raise_error(E_NLSTR);
                  else push_text(c);
               M_CHR_FIRST:
                  if (c == "'") raise_error(E_EMPTY);
                  else if (c == "\\") mode = M_CHR_ESC;
                  else begin chr_val = c; mode = M_CHR_SKIP; end
               M_CHR_ESC: begin chr_val = decode_escape(c); mode = M_CHR_SKIP; end
               M_CHR_SKIP:
                  if (c == "'") begin
                     put(K_INT, {{24{chr_val[7]}}, chr_val}, line_no, col_no, E_NONE);
                     mode = M_START;
                  end
               M_LINE_CMT: if (c == 8'd10) mode = M_START;
               M_BLOCK_CMT: begin
                  if (star && c == "/") mode = M_START;
                  star = (c == "*");
               end
               M_OP:
                  if (pend_op == K_SLASH && c == "*") begin star = 0; mode = M_BLOCK_CMT; end
                  else if (pend_op == K_SLASH && c == "/") mode = M_LINE_CMT;
                  else if (pend_op == K_DOT && c == ".") mode = M_DOTS2;
                  else begin
                     ext = grow_op(pend_op, c);
                     if (ext == K_LSHIFT || ext == K_RSHIFT) pend_op = ext;
                     else if (ext != K_INT) begin
                        put(ext, 0, line_no, col_no, E_NONE); mode = M_START;
                     end else begin put(pend_op, 0, ol, oc, E_NONE); redo = 1; end
                  end
               M_DOTS2:
                  if (c == ".") begin put(K_DOTS, 0, line_no, col_no, E_NONE); mode = M_START; end
                  else raise_error(E_DOTS);
               default: ;
            endcase
            if (redo) open_token(c);
            if (mode == M_ERROR && step_q.size() > 0 && step_q[$].kind == K_ERROR)
               error_tokens++;
         end
         if (step_q.size() > 0) step_q[$].last = 1;
         foreach (step_q[i]) owed_q.push_back(step_q[i]);
      endfunction

      // compare one delivered word against the oldest owed token
      function void check_word(logic [79:0] d, bit last);
         token_word t;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token word %h last %b", d, last);
            return;
         end
         t = owed_q.pop_front();
         if (d[6:0] !== t.kind || d[38:7] !== t.value || d[54:39] !== t.line ||
             d[70:55] !== t.column || d[73:71] !== t.err || last !== t.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("token mismatch: expected kind %0d value %h line %0d col %0d ",
                  "err %0d last %b, got kind %0d value %h line %0d col %0d err %0d last %b",
                  t.kind, t.value, t.line, t.column, t.err, t.last,
                  d[6:0], d[38:7], d[54:39], d[70:55], d[73:71], last);
         end else tokens_ok++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;   // source_byte
   logic        req_tuser = 0;   // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;      // kind, value, line, column, error_code
   logic        rsp_tlast;      // last

   token_scoreboard sb = new();
   int  send_idle_pct = 28;
   int  recv_idle_pct = 58;
   bit  hold_off = 0;
   int  cycle_count = 0;
   event long_stall;

   c_source_tokenizer_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // receiver: random back-pressure, or a long hold-off when asked
   always @(posedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      forever begin
         @(long_stall);
         hold_off = 1;
         repeat (300) @(posedge clock);
         hold_off = 0;
      end
   end

   // collect delivered tokens
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
   end

   initial begin
      wait (cycle_count > CYCLE_LIMIT);
      $display("timeout with %0d tokens owed", sb.owed_q.size());
      $display("tb_c_source_tokenizer_top failed");
      $finish;
   end

   // offer one word and hold it until taken
   task automatic send_word(logic [7:0] b, bit eoi);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= b;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, eoi);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 0);
   endtask

   task automatic send_end();
      send_word(8'($urandom_range(0, 255)), 1);
   endtask

   // pause the source until every owed token has come back
   task automatic drain();
      req_tvalid <= 0;
      wait (sb.owed_q.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic string random_name(int n);
      string s;
      string pool;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      s = "";
      for (int i = 0; i < n; i++)
         s = {s, string'(pool[(i == 0) ? $urandom_range(0, 52) : $urandom_range(0, 62)])};
      return s;
   endfunction

   // one piece of plausible C text, random in content
   function automatic string random_piece();
      string ops [] = '{"+", "-", "*", "/", "%", "(", ")", "<<", ">>", "<", ">", "<=",
         ">=", "==", "!=", "&", "^", "!", "|", "&&", "||", "=", "+=", "-=", "*=",
         "/=", "%=", "&=", "^=", "|=", "<<=", ">>=", ";", ",", ".", "->", "{", "}",
         ":", "?", "[", "]", "++", "--", "...", "#", "~", "\n"};
      string kws [] = '{"return", "if", "else", "while", "break", "continue", "for",
         "int", "char", "sizeof", "switch", "default", "case", "goto", "struct",
         "typedef", "do", "void", "union", "enum", "static", "extern", "const",
         "_Noreturn", "_Noreturnx", "consts", "whil"};
      string esc = "ntr0abfv\\'\"qx";
      case ($urandom_range(0, 15))
         0, 1: return random_name($urandom_range(1, 12));
         2, 3: return kws[$urandom_range(0, kws.size() - 1)];
         4:  return $sformatf("%0d", $urandom_range(0, 1000));
         5:  return $sformatf("%0d%0d", $urandom, $urandom);
         6:  return $urandom_range(0, 1) ? $sformatf("0x%0h", $urandom)
                                         : $sformatf("0X%0H", $urandom_range(0, 4095));
         7:  return $urandom_range(0, 2) == 0 ? "0x" : $sformatf("0%0o", $urandom);
         8:  return $urandom_range(0, 1) ? "089" : "0777777777777";
         9:  return {"\"", random_name($urandom_range(0, 5)), "\\",
                     string'(esc[$urandom_range(0, 12)]), "\""};
         10: return $urandom_range(0, 4) == 0 ? "''" :
                    $urandom_range(0, 1) ? {"'\\", string'(esc[$urandom_range(0, 12)]), "'"}
                                         : {"'", random_name($urandom_range(1, 3)), "'"};
         11: return $urandom_range(0, 1) ? {"/* ", random_name(3), " **/"}
                                         : {"// ", random_name(4), "\n"};
         12: return $urandom_range(0, 3) == 0 ? "..x" : " \t\r";
         default: return ops[$urandom_range(0, ops.size() - 1)];
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: names, keywords, numbers, escapes, comments, dots, errors
      send_text("_Noreturn const x<<=0x");  send_end();
      send_text("'\\n''\\377'089 \"\\ta\"");  send_end();
      send_text("/*a**/..-> ''");            send_end();
      send_text("\"ab\n");                   send_end();
      send_word(8'h00, 0);                   send_end();
      send_word(8'hFF, 0);                   send_end();
      send_text("/* ");                      send_end();
      drain();

      // random source text; three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 58 : 0;
         recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 28 : 0;
         while (sb.bytes_seen + sb.ends_seen < (ph + 1) * ITEM_TARGET / 3) begin
            if (ph == 1 && !hold_off && sb.bytes_seen % 97 == 0 && sb.ends_seen % 3 == 0)
               -> long_stall;
            case ($urandom_range(0, 39))
               0, 1: send_end();
               2:    send_word(8'($urandom_range(0, 255)), 0);
               default: begin
                  send_text(random_piece());
                  if ($urandom_range(0, 2) == 0) send_text(" ");
               end
            endcase
         end
         send_end();
         drain();
      end
      -> long_stall;
      send_text("a=b+c;\nx");
      send_end();
      drain();

      $display("covered %0d source bytes and %0d end marks, %0d tokens matched",
         sb.bytes_seen, sb.ends_seen, sb.tokens_ok);
      $display("lexer errors predicted %0d, mismatches %0d", sb.error_tokens, sb.mismatches);
      if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
         $display("tb_c_source_tokenizer_top passed");
      end else begin
         $display("tb_c_source_tokenizer_top failed");
      end
      $finish;
   end

   initial sb.clear_lexer();
endmodule
`default_nettype wire

// ===== sim.f =====
src/cst_pkg.sv
src/cst_kw_match.sv
src/c_source_tokenizer_top.sv
tb/tb_c_source_tokenizer_top.sv
